// ----- rtl/tdts_pkg.sv -----
// Package for the tick-driven task scheduler: sizes, command and status codes,
// entry and transaction types, and the small helper used by the top level.
// No dependencies.
`default_nettype none

package tdts_pkg;

	localparam int MAX_TASKS   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W       = $clog2(MAX_TASKS + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		CMD_ADD        = 3'd0,
		CMD_TICK       = 3'd1,
		CMD_DISPATCH   = 3'd2,
		CMD_DELETE     = 3'd3,
		CMD_DELETE_ALL = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_e;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TICK,
		CELL_SHIFT,
		CELL_DEC,
		CELL_CLEAR
	} cell_op_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_e;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] task_handle;
		logic [31:0] start_delay;
		logic [31:0] period;
		logic [7:0]  slot;
	} sched_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  result_slot;
		logic [15:0] run_handle;
		logic        run_valid;
		logic        last;
	} sched_out_t;

	typedef struct packed {
		logic        occupied;
		logic        one_shot;
		logic [15:0] handle;
		logic [31:0] delay;
		logic [31:0] period;
		logic [7:0]  runs;
	} entry_t;

	typedef struct packed {
		cell_op_e op;
		entry_t   load;
	} cell_ctl_t;

	function automatic logic [2:0] to_slot(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[2:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tdts_cell.sv -----
// One table entry of the scheduler chain; takes its upper neighbour's entry on a shift.
// Depends on tdts_pkg.
`default_nettype none

module tdts_cell
	import tdts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire entry_t    nxt,
	output entry_t         ent
);

	logic        occ_q;
	logic        one_shot_q;
	logic [15:0] handle_q;
	logic [31:0] delay_q;
	logic [31:0] period_q;
	logic [7:0]  runs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				CELL_LOAD:  occ_q <= 1'b1;
				CELL_SHIFT: occ_q <= nxt.occupied;
				CELL_CLEAR: occ_q <= 1'b0;
				default:    occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_LOAD: begin
				one_shot_q <= ctl.load.one_shot;
				handle_q   <= ctl.load.handle;
				delay_q    <= ctl.load.delay;
				period_q   <= ctl.load.period;
				runs_q     <= '0;
			end
			CELL_SHIFT: begin
				one_shot_q <= nxt.one_shot;
				handle_q   <= nxt.handle;
				delay_q    <= nxt.delay;
				period_q   <= nxt.period;
				runs_q     <= nxt.runs;
			end
			CELL_TICK: begin
				if (occ_q) begin
					if (delay_q == '0) begin
						if (runs_q != 8'hFF) begin
							runs_q <= runs_q + 8'd1;
						end
						if (period_q != '0) begin
							delay_q <= period_q;
						end
					end else begin
						delay_q <= delay_q - 32'd1;
					end
				end
			end
			CELL_DEC: begin
				runs_q <= runs_q - 8'd1;
			end
			CELL_CLEAR: begin
				one_shot_q <= 1'b0;
				handle_q   <= '0;
				delay_q    <= '0;
				period_q   <= '0;
				runs_q     <= '0;
			end
			default: begin
			end
		endcase
	end

	assign ent = '{
		occupied: occ_q,
		one_shot: one_shot_q,
		handle:   handle_q,
		delay:    delay_q,
		period:   period_q,
		runs:     runs_q
	};

endmodule

`default_nettype wire

// ----- rtl/tick_driven_task_scheduler.sv -----
// Tick-driven task scheduler: a chain of MAX_TASKS entry cells with a command sequencer.
// Add, tick, delete and delete-all: the work is done on acceptance, the response is staged
// in the held register, and the next command is taken once it is pushed to the output register.
// Dispatch: a scan of one cell per cycle, ending at the table end or after MAX_RESULTS runs,
// then the last response is delivered the same way, and the next command is taken after it;
// a found run waits while the previous one cannot leave a stalled output.
// arst_n empties the table and the count; no clearing pass is needed.
// Depends on tdts_pkg and tdts_cell.
`default_nettype none

module tick_driven_task_scheduler
	import tdts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire sched_in_t cmd,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output sched_out_t     rsp
);

	// Sequencer state
	state_e            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;   // tasks in table (table is compacted)
	logic [CNT_W-1:0]  idx_q, idx_d;       // dispatch scan position
	logic [RES_W-1:0]  nres_q, nres_d;     // runs emitted in this dispatch
	// Held response: a dispatch result waits here until we know whether it is the last
	sched_out_t        held_q, held_d;
	logic              held_v_q, held_v_d;

	// Output register
	sched_out_t        out_q;
	logic              out_v_q;
	logic              push;
	sched_out_t        push_data;
	logic              out_free;

	// Cell chain
	cell_ctl_t         ctl   [MAX_TASKS];
	entry_t            ent   [MAX_TASKS];
	entry_t            nxt   [MAX_TASKS];
	logic [MAX_TASKS-1:0] occ_vec;

	entry_t            cur;
	logic              hit;
	logic              scan_end;
	logic              accept;
	logic              slot_ok;
	entry_t            new_ent;

	assign out_free  = !out_v_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	// ---------------------------------------------------------------------
	// Chain: each cell takes its upper neighbour's entry on a shift;
	// the top cell takes an empty entry.
	// ---------------------------------------------------------------------
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		if (i == MAX_TASKS - 1) begin : g_top
			assign nxt[i] = '0;
		end else begin : g_mid
			assign nxt[i] = ent[i+1];
		end
		assign occ_vec[i] = ent[i].occupied;

		tdts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[i]),
			.nxt    (nxt[i]),
			.ent    (ent[i])
		);
	end

	// Entry under the scan pointer
	always_comb begin
		cur = '0;
		if (idx_q < CNT_W'(MAX_TASKS)) begin
			cur = ent[idx_q[IDX_W-1:0]];
		end
	end

	assign hit      = cur.occupied && (cur.runs != '0);
	assign scan_end = (idx_q >= CNT_W'(MAX_TASKS)) || (nres_q >= RES_W'(MAX_RESULTS));

	// Delete target must be inside the table and occupied
	always_comb begin
		slot_ok = 1'b0;
		if (32'(cmd.slot) < MAX_TASKS) begin
			slot_ok = ent[cmd.slot[IDX_W-1:0]].occupied;
		end
	end

	always_comb begin
		new_ent = '{
			occupied: 1'b1,
			one_shot: (cmd.period == '0),
			handle:   cmd.task_handle,
			delay:    cmd.start_delay,
			period:   cmd.period,
			runs:     8'd0
		};
	end

	// ---------------------------------------------------------------------
	// Sequencer: next state, cell commands and response staging
	// ---------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		nres_d    = nres_q;
		held_d    = held_q;
		held_v_d  = held_v_q;
		push      = 1'b0;
		push_data = held_q;
		for (int i = 0; i < MAX_TASKS; i++) begin
			ctl[i] = '{op: CELL_HOLD, load: new_ent};
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					held_d   = '{status: ST_OK, result_slot: 3'd0, run_handle: 16'd0,
						run_valid: 1'b0, last: 1'b1};
					held_v_d = 1'b1;
					state_d  = S_FIN;
					unique case (cmd.command)
						CMD_ADD: begin
							if (count_q >= CNT_W'(MAX_TASKS)) begin
								held_d.status = ST_FULL;
							end else begin
								ctl[count_q[IDX_W-1:0]].op = CELL_LOAD;
								held_d.result_slot = to_slot(count_q);
								count_d = count_q + CNT_W'(1);
							end
						end
						CMD_TICK: begin
							for (int i = 0; i < MAX_TASKS; i++) begin
								ctl[i].op = CELL_TICK;
							end
						end
						CMD_DISPATCH: begin
							held_v_d = 1'b0;
							idx_d    = '0;
							nres_d   = '0;
							state_d  = S_SCAN;
						end
						CMD_DELETE: begin
							held_d.result_slot = cmd.slot[2:0];
							if (!slot_ok) begin
								held_d.status = ST_BAD;
							end else begin
								for (int i = 0; i < MAX_TASKS; i++) begin
									if (i >= int'(cmd.slot)) begin
										ctl[i].op = CELL_SHIFT;
									end
								end
								count_d = count_q - CNT_W'(1);
							end
						end
						CMD_DELETE_ALL: begin
							for (int i = 0; i < MAX_TASKS; i++) begin
								ctl[i].op = CELL_CLEAR;
							end
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end

			S_SCAN: begin
				if (scan_end) begin
					if (!held_v_q) begin
						held_d = '{status: ST_OK, result_slot: 3'd0, run_handle: 16'd0,
							run_valid: 1'b0, last: 1'b1};
					end
					held_v_d = 1'b1;
					state_d  = S_FIN;
				end else if (hit) begin
					// A new run flushes the previous one (not last) to the output
					if (!held_v_q || out_free) begin
						if (held_v_q) begin
							push           = 1'b1;
							push_data      = held_q;
							push_data.last = 1'b0;
						end
						held_d   = '{status: ST_OK, result_slot: to_slot(idx_q),
							run_handle: cur.handle, run_valid: 1'b1, last: 1'b0};
						held_v_d = 1'b1;
						nres_d   = nres_q + RES_W'(1);
						if (cur.one_shot) begin
							// remove and compact; the entry shifted in waits for next dispatch
							for (int i = 0; i < MAX_TASKS; i++) begin
								if (i >= int'(idx_q)) begin
									ctl[i].op = CELL_SHIFT;
								end
							end
							count_d = count_q - CNT_W'(1);
						end else begin
							ctl[idx_q[IDX_W-1:0]].op = CELL_DEC;
						end
						idx_d = idx_q + CNT_W'(1);
					end
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end

			S_FIN: begin
				if (out_free) begin
					push           = 1'b1;
					push_data      = held_q;
					push_data.last = 1'b1;
					held_v_d       = 1'b0;
					state_d        = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			nres_q   <= '0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			nres_q   <= nres_d;
			held_v_q <= held_v_d;
			if (push) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
		if (push) begin
			out_q <= push_data;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	logic [MAX_TASKS-1:0] occ_exp;
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			occ_exp[i] = (i < int'(count_q));
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("task count beyond table size");

	a_compacted: assert property (@(posedge clk) disable iff (!arst_n)
		occ_vec == occ_exp)
		else $error("occupied entries not a prefix matching the count");

	a_fin_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && out_free |=> (state_q == S_IDLE))
		else $error("final response not delivered");

	a_mid_is_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.run_valid)
		else $error("non-final response without a run");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= CNT_W'(MAX_TASKS)))
		else $error("scan pointer overran table");

endmodule

`default_nettype wire
